// ===== design/ecs_pkg.sv =====
package ecs_pkg;

	// Width of a floor number on the ports
	localparam int unsigned FLOOR_W = 5;

	// Event kinds on req_type
	typedef enum logic [1:0] {
		KIND_CALL   = 2'd0,
		KIND_ARRIVE = 2'd1,
		KIND_PASS   = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	// Travel direction codes
	typedef enum logic [1:0] {
		DIR_STAY = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_TGT,
		ST_START,
		ST_SCAN,
		ST_OUT
	} state_t;

endpackage

// ===== design/elevator_call_scheduler_core.sv =====
// Elevator call scheduler. Each word on the input channel is one event (new call,
// arrival at a floor, floor passed); a call always yields one result word, an arrival
// while busy yields one unless no marked floor lies on the scan side, and a pass or an
// arrival while free yields none. Floors outside 1..FLOOR_COUNT and the unused event
// kind are dropped. All searches run through a single floor counter and one mark test
// per cycle: a call passes a start step and then scans floor by floor from the car
// toward the target before the result appears; an arrival at the far target first
// runs a target search. The block takes no new word until the result word has
// been taken. No clearing pass after reset is needed.
module elevator_call_scheduler_core #(
	parameter int unsigned FLOOR_COUNT = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    req_type,
	input  logic [ecs_pkg::FLOOR_W-1:0]   floor_num,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [ecs_pkg::FLOOR_W-1:0]   stop_floor,
	output logic                          move_up
);

	localparam int unsigned CW   = $clog2(FLOOR_COUNT + 2);
	localparam int unsigned IDXW = (CW > ecs_pkg::FLOOR_W) ? CW : ecs_pkg::FLOOR_W;
	localparam int unsigned IW   = $clog2(FLOOR_COUNT);

	ecs_pkg::state_t                state_q, state_d;
	logic [FLOOR_COUNT-1:0]         marks_q, marks_d;
	logic [ecs_pkg::FLOOR_W-1:0]    car_q, car_d;
	logic [ecs_pkg::FLOOR_W-1:0]    far_q, far_d;
	ecs_pkg::dir_t                  dir_q, dir_d;
	logic                           busy_q, busy_d;
	logic [IDXW-1:0]                idx_q, idx_d;
	logic                           step_up_q, step_up_d;
	logic                           is_call_q, is_call_d;
	logic [ecs_pkg::FLOOR_W-1:0]    call_fl_q, call_fl_d;
	logic [ecs_pkg::FLOOR_W-1:0]    stop_q, stop_d;
	logic                           move_up_q, move_up_d;

	logic                           floor_ok;
	logic [IDXW-1:0]                fl_x;
	logic [FLOOR_COUNT-1:0]         call_mask;
	logic [IDXW-1:0]                idx_m1;
	logic                           idx_in_range;
	logic                           idx_hit;
	logic [IDXW-1:0]                idx_step;
	logic [ecs_pkg::FLOOR_W-1:0]    ft0;

	// Decode the incoming floor
	assign fl_x     = IDXW'(floor_num);
	assign floor_ok = (floor_num != '0) && (fl_x <= IDXW'(FLOOR_COUNT));

	always_comb begin
		for (int i = 0; i < FLOOR_COUNT; i++) begin
			call_mask[i] = (fl_x == IDXW'(i + 1));
		end
	end

	// Shared floor counter: range check, mark test and step
	assign idx_m1       = idx_q - IDXW'(1);
	assign idx_in_range = (idx_q != '0) && (idx_q <= IDXW'(FLOOR_COUNT));
	assign idx_hit      = idx_in_range && marks_q[idx_m1[IW-1:0]];
	assign idx_step     = step_up_q ? (idx_q + IDXW'(1)) : (idx_q - IDXW'(1));

	// Target after a call, before direction extension
	assign ft0 = (far_q == '0) ? floor_num : far_q;

	// Next state and outputs
	always_comb begin
		state_d   = state_q;
		marks_d   = marks_q;
		car_d     = car_q;
		far_d     = far_q;
		dir_d     = dir_q;
		busy_d    = busy_q;
		idx_d     = idx_q;
		step_up_d = step_up_q;
		is_call_d = is_call_q;
		call_fl_d = call_fl_q;
		stop_d    = stop_q;
		move_up_d = move_up_q;
		in_ready  = (state_q == ecs_pkg::ST_IDLE);
		out_valid = (state_q == ecs_pkg::ST_OUT);

		case (state_q)
			ecs_pkg::ST_IDLE: begin
				if (in_valid && floor_ok) begin
					case (req_type)
						ecs_pkg::KIND_CALL: begin
							busy_d    = 1'b1;
							marks_d   = marks_q | call_mask;
							is_call_d = 1'b1;
							call_fl_d = floor_num;
							if ((dir_q == ecs_pkg::DIR_UP && floor_num > ft0) ||
							    (dir_q == ecs_pkg::DIR_DOWN && floor_num < ft0)) begin
								far_d = floor_num;
							end else begin
								far_d = ft0;
							end
							state_d = ecs_pkg::ST_START;
						end
						ecs_pkg::KIND_ARRIVE: begin
							if (busy_q) begin
								car_d     = floor_num;
								marks_d   = marks_q & ~call_mask;
								is_call_d = 1'b0;
								if (floor_num == far_q) begin
									// target reached: search a new one
									far_d = '0;
									if (dir_q == ecs_pkg::DIR_UP) begin
										idx_d     = IDXW'(FLOOR_COUNT);
										step_up_d = 1'b0;
									end else begin
										idx_d     = IDXW'(1);
										step_up_d = 1'b1;
									end
									state_d = ecs_pkg::ST_TGT;
								end else begin
									state_d = ecs_pkg::ST_START;
								end
							end
						end
						ecs_pkg::KIND_PASS: begin
							car_d = floor_num;
						end
						default: begin
						end
					endcase
				end
			end
			ecs_pkg::ST_TGT: begin
				if (!idx_in_range) begin
					state_d = ecs_pkg::ST_START;
				end else if (idx_hit) begin
					far_d   = ecs_pkg::FLOOR_W'(idx_q);
					state_d = ecs_pkg::ST_START;
				end else begin
					idx_d = idx_step;
				end
			end
			ecs_pkg::ST_START: begin
				// scan from the car toward the target
				step_up_d = (far_q > car_q);
				idx_d     = IDXW'(car_q);
				state_d   = ecs_pkg::ST_SCAN;
			end
			ecs_pkg::ST_SCAN: begin
				if (idx_hit || (!idx_in_range && is_call_q)) begin
					stop_d    = idx_hit ? ecs_pkg::FLOOR_W'(idx_q) : call_fl_q;
					dir_d     = (car_q > far_q) ? ecs_pkg::DIR_DOWN : ecs_pkg::DIR_UP;
					move_up_d = !(car_q > far_q);
					state_d   = ecs_pkg::ST_OUT;
				end else if (!idx_in_range) begin
					busy_d  = 1'b0;
					state_d = ecs_pkg::ST_IDLE;
				end else begin
					idx_d = idx_step;
				end
			end
			ecs_pkg::ST_OUT: begin
				if (out_ready) begin
					state_d = ecs_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ecs_pkg::ST_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ecs_pkg::ST_IDLE;
			marks_q <= '0;
			car_q   <= ecs_pkg::FLOOR_W'(1);
			far_q   <= '0;
			dir_q   <= ecs_pkg::DIR_STAY;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			marks_q <= marks_d;
			car_q   <= car_d;
			far_q   <= far_d;
			dir_q   <= dir_d;
			busy_q  <= busy_d;
		end
	end

	// Hold scan and result payload
	always_ff @(posedge clk) begin
		idx_q     <= idx_d;
		step_up_q <= step_up_d;
		is_call_q <= is_call_d;
		call_fl_q <= call_fl_d;
		stop_q    <= stop_d;
		move_up_q <= move_up_d;
	end

	assign stop_floor = stop_q;
	assign move_up    = move_up_q;

	// A pending result blocks new words
	a_out_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input ready while a result word is pending");

	// Reported floors lie in range
	a_stop_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (stop_floor != '0 && IDXW'(stop_floor) <= IDXW'(FLOOR_COUNT)))
		else $error("stop floor out of range");

	// A valid call makes the block busy
	a_call_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && floor_ok && req_type == ecs_pkg::KIND_CALL) |=> busy_q)
		else $error("call did not set busy");

	// Searches only run while busy
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ecs_pkg::ST_SCAN || state_q == ecs_pkg::ST_TGT) |-> busy_q)
		else $error("floor search while free");

	// Car position never reads zero
	a_car_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		car_q != '0)
		else $error("car floor is zero");

endmodule
